// ===== src/lpsf_pkg.sv =====
// types and constants shared by the lp synthesis filter
package lpsf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int ACC_W      = 32;
    localparam int SHIFT_Q    = 12;
    localparam int COEF_REGS  = 3;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int SLOTS_PER_REG = CFG_W / SAMPLE_W;

    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN = -16'sd32767;

    localparam logic [ACC_W-1:0] ROUND_ADD = ACC_W'(1) << (SHIFT_Q - 1);

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_COEF_0_3  = 2'd0,
        CFG_COEF_4_7  = 2'd1,
        CFG_COEF_8_11 = 2'd2,
        CFG_UNUSED    = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_MAC  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

// ===== src/lp_synthesis_filter_top.sv =====
// all-pole lp synthesis filter with one shared multiply-accumulate unit
//
//  channel     | signals                          | direction
//  ------------+----------------------------------+----------
//  input       | in_valid, in_stall, excitation   | in
//  output      | out_valid, out_stall, speech_out | out
//  config      | cfg_we, cfg_index, cfg_data      | in
//
//  each sample goes through accept, one multiply-accumulate per tap, finish
//  the finish cycle waits while a previous result is still stalled in the output register
//  in_stall is high from accept until the result has been moved to the output register
//  reset clears coefficients, history and all control state
module lp_synthesis_filter_top
    import lpsf_pkg::*;
#(
    parameter int ORDER = 10
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [SAMPLE_W-1:0]  excitation,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [SAMPLE_W-1:0]  speech_out,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data
);

    localparam int TAP_W = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(ORDER - 1);

    state_t                      state_reg, state_next;
    logic [TAP_W-1:0]            tap_reg, tap_next;
    logic [ACC_W-1:0]            acc_reg, acc_next;
    logic [CFG_W-1:0]            coef_reg [COEF_REGS];
    logic signed [SAMPLE_W-1:0]  hist_reg [ORDER];
    logic                        out_valid_reg;
    logic signed [SAMPLE_W-1:0]  out_data_reg;

    logic signed [SAMPLE_W-1:0]  coef_slot [ORDER];
    logic signed [SAMPLE_W-1:0]  coef_sel;
    logic signed [SAMPLE_W-1:0]  hist_sel;
    logic signed [ACC_W-1:0]     product;
    logic [ACC_W-1:0]            rounded;
    logic signed [ACC_W-SHIFT_Q-1:0] scaled;
    logic signed [SAMPLE_W-1:0]  clamped;
    logic                        in_accept;
    logic                        out_free;
    logic                        finish;

    genvar g;
    generate
        for (g = 0; g < ORDER; g++)
        begin : g_slot
            assign coef_slot[g] =
                coef_reg[g / SLOTS_PER_REG][(g % SLOTS_PER_REG) * SAMPLE_W +: SAMPLE_W];
        end
    endgenerate

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign finish    = (state_reg == ST_DONE) && out_free;

    assign out_valid  = out_valid_reg;
    assign speech_out = out_data_reg;

    // shared multiply-accumulate
    always_comb
    begin
        coef_sel = coef_slot[tap_reg];
        hist_sel = hist_reg[tap_reg];
        product  = ACC_W'(coef_sel) * ACC_W'(hist_sel);
    end

    // rounding and clamp
    always_comb
    begin
        rounded = acc_reg + ROUND_ADD;
        scaled  = rounded[ACC_W-1:SHIFT_Q];
        if (scaled > (ACC_W-SHIFT_Q)'(OUT_MAX))
            clamped = OUT_MAX;
        else if (scaled < (ACC_W-SHIFT_Q)'(OUT_MIN))
            clamped = OUT_MIN;
        else
            clamped = scaled[SAMPLE_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        acc_next   = acc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    acc_next   = ACC_W'(excitation) << SHIFT_Q;
                    tap_next   = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                acc_next = acc_reg - product;
                if (tap_reg == LAST_TAP)
                    state_next = ST_DONE;
                else
                    tap_next = tap_reg + TAP_W'(1);
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEF_REGS; i++)
                coef_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COEF_0_3:  coef_reg[0] <= cfg_data;
                CFG_COEF_4_7:  coef_reg[1] <= cfg_data;
                CFG_COEF_8_11: coef_reg[2] <= cfg_data;
                default:       ;
            endcase
        end
    end

    // output history, newest first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ORDER; i++)
                hist_reg[i] <= '0;
        end
        else if (finish)
        begin
            for (int i = ORDER - 1; i > 0; i--)
                hist_reg[i] <= hist_reg[i-1];
            hist_reg[0] <= clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
            out_data_reg <= clamped;
    end

    a_accept_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_MAC) && (tap_reg == '0))
        else $error("accepted transaction did not start the tap sequence");

    a_last_tap_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) && (tap_reg == LAST_TAP) |=> (state_reg == ST_DONE))
        else $error("tap sequence did not end after the last tap");

    a_finish_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid_reg && (hist_reg[0] == out_data_reg))
        else $error("result and history disagree after finish");

    a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg != -16'sd32768))
        else $error("output transaction outside clamp range");

endmodule

// ===== sim/lp_synthesis_filter_tb.sv =====
// self-checking testbench for the lp synthesis filter with a built-in filter predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lpsf_pkg::*;

    localparam int FILTER_ORDER   = 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_ITEMS    = 140;

    typedef enum int
    {
        COEF_RANDOM,
        COEF_SMALL,
        COEF_MOST_NEG,
        COEF_MOST_POS,
        COEF_RESONANT,
        COEF_ZERO
    } coef_kind_t;

    class speech_scoreboard;
        logic [CFG_W-1:0]           coef_reg [COEF_REGS];
        logic signed [SAMPLE_W-1:0] past_out [FILTER_ORDER];
        logic signed [SAMPLE_W-1:0] expected_speech [$];
        int                         errors;

        function new();
            foreach (coef_reg[i])
            begin
                coef_reg[i] = '0;
            end
            foreach (past_out[i])
            begin
                past_out[i] = '0;
            end
            errors = 0;
        endfunction

        function void write_coef(cfg_index_t idx, logic [CFG_W-1:0] data);
            if (int'(idx) < COEF_REGS)
            begin
                coef_reg[int'(idx)] = data;
            end
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] x);
            logic [ACC_W-1:0]           acc;
            logic signed [ACC_W-1:0]    coef_w;
            logic signed [ACC_W-1:0]    hist_w;
            logic signed [ACC_W-1:0]    rounded;
            logic signed [SAMPLE_W-1:0] y;
            acc = {{(ACC_W - SAMPLE_W){x[SAMPLE_W-1]}}, x} << SHIFT_Q;
            for (int j = 0; j < FILTER_ORDER; j++)
            begin
                coef_w = $signed(coef_reg[j / SLOTS_PER_REG]
                                 [(j % SLOTS_PER_REG) * SAMPLE_W +: SAMPLE_W]);
                hist_w = past_out[j];
                acc = acc - ACC_W'(coef_w * hist_w);
            end
            rounded = $signed(acc + ROUND_ADD) >>> SHIFT_Q;
            if (rounded > OUT_MAX)
            begin
                y = OUT_MAX;
            end
            else if (rounded < OUT_MIN)
            begin
                y = OUT_MIN;
            end
            else
            begin
                y = rounded[SAMPLE_W-1:0];
            end
            for (int j = FILTER_ORDER - 1; j > 0; j--)
            begin
                past_out[j] = past_out[j - 1];
            end
            past_out[0] = y;
            expected_speech.push_back(y);
        endfunction

        function void check_speech(logic signed [SAMPLE_W-1:0] actual);
            logic signed [SAMPLE_W-1:0] want;
            if (expected_speech.size() == 0)
            begin
                $error("speech_out: expected no transaction, actual %0d", actual);
                errors++;
                return;
            end
            want = expected_speech.pop_front();
            if (actual !== want)
            begin
                $error("speech_out: expected %0d, actual %0d", want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return expected_speech.size();
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] excitation = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] speech_out;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data = '0;

    speech_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    lp_synthesis_filter_top #(.ORDER(FILTER_ORDER)) dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .excitation (excitation),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .speech_out (speech_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_speech(speech_out);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("lp_synthesis_filter_top test failed");
                $finish;
            end
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_excitation();
        int sel;
        int v;
        sel = $urandom_range(99);
        if (sel < 40)
        begin
            v = $urandom;
        end
        else if (sel < 70)
        begin
            v = int'($urandom_range(512)) - 256;
        end
        else if (sel < 85)
        begin
            v = int'($urandom_range(8192)) - 4096;
        end
        else
        begin
            case ($urandom_range(4))
                0: v = 32767;
                1: v = -32768;
                2: v = 1;
                3: v = -1;
                default: v = 0;
            endcase
        end
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic [CFG_W-1:0] make_coef_reg(coef_kind_t kind, int reg_idx);
        logic [CFG_W-1:0] word;
        int               c;
        int               tap;
        word = '0;
        for (int s = 0; s < SLOTS_PER_REG; s++)
        begin
            tap = reg_idx * SLOTS_PER_REG + s;
            case (kind)
                COEF_RANDOM:   c = $urandom;
                COEF_SMALL:    c = int'($urandom_range(1024)) - 512;
                COEF_MOST_NEG: c = -32768;
                COEF_MOST_POS: c = 32767;
                COEF_RESONANT:
                begin
                    if (tap == 0)
                    begin
                        c = -int'($urandom_range(4096, 2048));
                    end
                    else if (tap == 1)
                    begin
                        c = $urandom_range(2048);
                    end
                    else
                    begin
                        c = int'($urandom_range(256)) - 128;
                    end
                end
                default:       c = 0;
            endcase
            word[s * SAMPLE_W +: SAMPLE_W] = c[SAMPLE_W-1:0];
        end
        return word;
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        excitation <= x;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_sample(x);
        @(negedge clk);
    endtask

    task automatic load_coefs(input logic [CFG_W-1:0] c0, c1, c2);
        logic [CFG_W-1:0] vals [4];
        vals = '{c0, c1, c2, {$urandom, $urandom}};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_data  <= vals[i];
            sb.write_coef(cfg_index_t'(i), vals[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (FILTER_ORDER + 4) @(negedge clk);
    endtask

    initial
    begin
        coef_kind_t kind;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // pass-through with zero taps, including the negative clamp
        load_coefs('0, '0, '0);
        send_sample(16'sd0);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        send_sample(16'sd2047);
        wait_drained();

        // most negative taps drive the accumulator into wrap
        load_coefs({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
        send_sample(16'sd32767);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(16'sd0);
        send_sample(16'sd0);
        send_sample(-16'sd32768);
        send_sample(16'sd1);
        wait_drained();

        // slots past the filter order are stored but unused
        load_coefs('0, '0, {16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000});
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd100);
        send_sample(-16'sd100);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drained();
            kind = coef_kind_t'(p % 6);
            load_coefs(make_coef_reg(kind, 0), make_coef_reg(kind, 1),
                       make_coef_reg(kind, 2));
            if (p < 3)
            begin
                send_idle_pct = 25;
                stall_pct     = 66;
            end
            else if (p < 6)
            begin
                send_idle_pct = 66;
                stall_pct     = 25;
            end
            else
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            repeat (PHASE_ITEMS) send_sample(pick_excitation());
        end
        wait_drained();

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("lp_synthesis_filter_top test passed");
        end
        else
        begin
            $display("lp_synthesis_filter_top test failed");
        end
        $finish;
    end

endmodule
